### hdl/odwm_pkg.sv
// Shared types, state codes and coefficient tables for the omni-drive wheel mixer.
// Tables are built at elaboration from an integer series in Q2.30; no dependencies.
`default_nettype none

package odwm_pkg;

    localparam int unsigned FULL_TURN  = 360;
    localparam int unsigned SECTOR_DEG = 60;
    localparam int unsigned DUTY_LIMIT = 100;
    localparam int unsigned DUTY_FULL  = 255;
    localparam int unsigned SERIES_TERMS = 9;
    localparam int unsigned COEF_W = 16;
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    localparam logic [2:0] SECTOR_OUT = 3'd6;

    typedef struct packed {
        logic [9:0] heading_deg;
        logic [7:0] drive_speed;
    } t_in;

    typedef struct packed {
        logic [7:0] duty_one;
        logic [7:0] duty_two;
        logic [7:0] duty_three;
        logic       dir_one;
        logic       dir_two;
        logic       dir_three;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_MUL,
        S_SUB,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic load;
        logic reduce;
        logic mul;
        logic sub;
        logic update;
    } t_cmd;

    // Shift-subtract quotient for table construction at elaboration.
    function automatic logic [63:0] const_div(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] series_q30(input int unsigned deg, input bit start_sin);
        logic [63:0]    r;
        logic [63:0]    term;
        logic [63:0]    n;
        longint signed  sum;
        r = (64'(deg) * PI_Q30) / 64'd180;
        term = start_sin ? r : ONE_Q30;
        sum = signed'(term);
        n = start_sin ? 64'd1 : 64'd0;
        for (int k = 1; k < SERIES_TERMS; k++) begin
            term = (term * r) >> 30;
            term = (term * r) >> 30;
            term = const_div(term, (n + 64'd1) * (n + 64'd2));
            n = n + 64'd2;
            if ((k & 1) != 0) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        return (sum < 0) ? 64'd0 : unsigned'(sum);
    endfunction

    function automatic logic [COEF_W-1:0] coef_kx(input int unsigned t);
        logic [63:0] s;
        logic [63:0] s60;
        logic [63:0] q;
        s = series_q30(t, 1'b1);
        s60 = series_q30(SECTOR_DEG, 1'b1);
        if (s60 == 64'd0) begin
            q = 64'd0;
        end else begin
            q = const_div((s << 16) + (s60 >> 1), s60);
        end
        return q[COEF_W-1:0];
    endfunction

    function automatic logic [COEF_W-1:0] coef_kc(input int unsigned t);
        logic [63:0] v;
        v = (series_q30(t, 1'b0) + (64'd1 << 13)) >> 14;
        return (v > 64'd65535) ? 16'hFFFF : v[COEF_W-1:0];
    endfunction

    function automatic logic [SECTOR_DEG*COEF_W-1:0] build_kx();
        logic [SECTOR_DEG*COEF_W-1:0] tbl;
        tbl = '0;
        for (int t = 0; t < SECTOR_DEG; t++) begin
            tbl[t*COEF_W +: COEF_W] = coef_kx(t);
        end
        return tbl;
    endfunction

    function automatic logic [SECTOR_DEG*COEF_W-1:0] build_kc();
        logic [SECTOR_DEG*COEF_W-1:0] tbl;
        tbl = '0;
        for (int t = 0; t < SECTOR_DEG; t++) begin
            tbl[t*COEF_W +: COEF_W] = coef_kc(t);
        end
        return tbl;
    endfunction

    function automatic logic [(DUTY_LIMIT+1)*8-1:0] build_duty();
        logic [(DUTY_LIMIT+1)*8-1:0] tbl;
        int unsigned                 d;
        tbl = '0;
        for (int unsigned w = 0; w <= DUTY_LIMIT; w++) begin
            d = (w * DUTY_FULL) / DUTY_LIMIT;
            tbl[w*8 +: 8] = d[7:0];
        end
        return tbl;
    endfunction

    localparam logic [SECTOR_DEG*COEF_W-1:0]     KX_TABLE   = build_kx();
    localparam logic [SECTOR_DEG*COEF_W-1:0]     KC_TABLE   = build_kc();
    localparam logic [(DUTY_LIMIT+1)*8-1:0]      DUTY_TABLE = build_duty();

endpackage

`default_nettype wire

### hdl/odwm_ctrl.sv
// Sequencer for the wheel mixer: accept, reduce, multiply, subtract, update.
// Depends on odwm_pkg for the state enum and the command struct.
`default_nettype none

module odwm_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    output odwm_pkg::t_cmd   o_cmd
);
    import odwm_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_REDUCE;
                end
            end
            S_REDUCE: begin
                o_cmd.reduce = 1'b1;
                n_state      = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUB;
            end
            S_SUB: begin
                o_cmd.sub = 1'b1;
                n_state   = S_UPDATE;
            end
            S_UPDATE: begin
                if (out_free) begin
                    o_cmd.update = 1'b1;
                    o_in_ready   = 1'b1;
                    if (i_in_valid) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_REDUCE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = o_cmd.update ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

endmodule

`default_nettype wire

### hdl/odwm_datapath.sv
// Datapath of the wheel mixer: heading reduction, coefficient multiplies and motor routing.
// Depends on odwm_pkg for payload types, commands and coefficient tables.
`default_nettype none

module odwm_datapath (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  odwm_pkg::t_cmd   i_cmd,
    input  odwm_pkg::t_in    i_in_data,
    output odwm_pkg::t_out   o_out_data
);
    import odwm_pkg::*;

    logic [9:0]  r_ang;
    logic [7:0]  r_spd;
    logic [2:0]  r_sector;
    logic [5:0]  r_t;
    logic [7:0]  r_x;
    logic [23:0] r_pc;
    logic [7:0]  r_y;
    logic [7:0]  r_duty [3];
    logic [2:0]  r_dir;

    logic [9:0]  ang_red;
    logic [2:0]  n_sector;
    logic [8:0]  sector_base;
    logic [8:0]  t_full;
    logic [15:0] kx;
    logic [15:0] kc;
    logic [23:0] px;
    logic [23:0] pc;
    logic [24:0] yq;
    logic [9:0]  q_full;
    logic [7:0]  val [3];
    logic [7:0]  wheel [3];
    logic [2:0]  n_dir;

    assign ang_red = (r_ang >= 10'(FULL_TURN)) ? r_ang - 10'(FULL_TURN) : r_ang;

    always_comb begin
        if (ang_red >= 10'(FULL_TURN)) begin
            n_sector = SECTOR_OUT;
        end else if (ang_red >= 10'd300) begin
            n_sector = 3'd5;
        end else if (ang_red >= 10'd240) begin
            n_sector = 3'd4;
        end else if (ang_red >= 10'd180) begin
            n_sector = 3'd3;
        end else if (ang_red >= 10'd120) begin
            n_sector = 3'd2;
        end else if (ang_red >= 10'd60) begin
            n_sector = 3'd1;
        end else begin
            n_sector = 3'd0;
        end
        sector_base = 9'(SECTOR_DEG) * {6'd0, (n_sector == SECTOR_OUT) ? 3'd0 : n_sector};
        t_full = ang_red[8:0] - sector_base;
    end

    assign kx = KX_TABLE[{r_t, 4'd0} +: COEF_W];
    assign kc = KC_TABLE[{r_t, 4'd0} +: COEF_W];
    assign px = {16'd0, r_spd} * {8'd0, kx};
    assign pc = {16'd0, r_spd} * {8'd0, kc};
    assign yq = {1'b0, r_pc} - {2'b0, r_x, 15'd0};

    assign q_full = ({2'd0, r_spd} + {1'b0, r_spd, 1'b0}) >> 2;

    always_comb begin
        if (r_t == 6'd0) begin
            val[0] = q_full[7:0];
            val[1] = q_full[7:0];
            val[2] = q_full[7:0];
        end else begin
            val[0] = r_x;
            val[1] = r_y;
            val[2] = 8'd0;
        end
        unique case (r_sector)
            3'd0, 3'd3: begin
                wheel[0] = val[1];
                wheel[1] = val[0];
                wheel[2] = val[2];
            end
            3'd1, 3'd4: begin
                wheel[0] = val[2];
                wheel[1] = val[1];
                wheel[2] = val[0];
            end
            3'd2, 3'd5: begin
                wheel[0] = val[0];
                wheel[1] = val[2];
                wheel[2] = val[1];
            end
            default: begin
                wheel[0] = 8'd0;
                wheel[1] = 8'd0;
                wheel[2] = 8'd0;
            end
        endcase
        unique case (r_sector)
            3'd0:    n_dir = 3'b100;
            3'd1:    n_dir = 3'b101;
            3'd2:    n_dir = 3'b001;
            3'd3:    n_dir = 3'b011;
            3'd4:    n_dir = 3'b010;
            3'd5:    n_dir = 3'b110;
            default: n_dir = 3'b110;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ang <= i_in_data.heading_deg;
            r_spd <= i_in_data.drive_speed;
        end
        if (i_cmd.reduce) begin
            r_sector <= n_sector;
            r_t      <= (n_sector == SECTOR_OUT) ? 6'd0 : t_full[5:0];
        end
        if (i_cmd.mul) begin
            r_x  <= px[23:16];
            r_pc <= pc;
        end
        if (i_cmd.sub) begin
            r_y <= yq[24] ? 8'd0 : yq[23:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < 3; m++) begin
                r_duty[m] <= 8'(DUTY_LIMIT);
            end
            r_dir <= 3'b000;
        end else if (i_cmd.update) begin
            for (int m = 0; m < 3; m++) begin
                if (wheel[m] <= 8'(DUTY_LIMIT)) begin
                    r_duty[m] <= DUTY_TABLE[{wheel[m][6:0], 3'd0} +: 8];
                end
            end
            r_dir <= n_dir;
        end
    end

    assign o_out_data.duty_one   = r_duty[0];
    assign o_out_data.duty_two   = r_duty[1];
    assign o_out_data.duty_three = r_duty[2];
    assign o_out_data.dir_one    = r_dir[2];
    assign o_out_data.dir_two    = r_dir[1];
    assign o_out_data.dir_three  = r_dir[0];

endmodule

`default_nettype wire

### hdl/omni_drive_wheel_mixer_core.sv
// A result is valid after its beat's reduce, multiply, subtract and update steps.
// The four-step sequencer in odwm_ctrl takes a new beat only when idle or updating.
// Reset (synchronous, active low): sequencer idle, no result pending, every held duty
// at 100 and every direction bit low.
// Depends on odwm_pkg, odwm_ctrl and odwm_datapath.
`default_nettype none

module omni_drive_wheel_mixer_core (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  odwm_pkg::t_in    i_in_data,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    output odwm_pkg::t_out   o_out_data
);
    import odwm_pkg::*;

    t_cmd cmd;

    odwm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    odwm_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire

### sim/omni_drive_wheel_mixer_core_test.sv
// Self-checking bench for omni_drive_wheel_mixer_core: heading/speed beats in, held duties out.
// Predicts held duties and directions from its own series tables; needs odwm_pkg and the core.
`timescale 1ns / 1ps

module omni_drive_wheel_mixer_core_test;

    import odwm_pkg::*;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_in  in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_data;

    t_in         heading_beats [$];
    t_out        duty_expect [$];
    int unsigned mismatches = 0;
    logic        in_taken = 1'b0;
    int unsigned in_gap = 0;
    int unsigned in_burst = 0;
    int unsigned out_stall = 0;
    int unsigned out_burst = 0;

    bit [7:0]    duty_hold [3];
    bit          dir_hold [3];
    int unsigned kx_tab [SECTOR_DEG];
    int unsigned kc_tab [SECTOR_DEG];

    omni_drive_wheel_mixer_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic bit [63:0] taylor_q30(int unsigned deg, bit want_sin);
        bit [63:0] rad;
        bit [63:0] term;
        bit [63:0] n;
        longint    acc;
        rad = (64'(deg) * 64'(PI_Q30)) / 64'd180;
        term = want_sin ? rad : (64'd1 << 30);
        acc = $signed(term);
        n = want_sin ? 64'd1 : 64'd0;
        for (int k = 1; k < 9; k++) begin
            term = (term * rad) >> 30;
            term = (term * rad) >> 30;
            term = term / ((n + 64'd1) * (n + 64'd2));
            n = n + 64'd2;
            if (k % 2 == 1) begin
                acc = acc - $signed(term);
            end else begin
                acc = acc + $signed(term);
            end
        end
        return (acc < 0) ? 64'd0 : $unsigned(acc);
    endfunction

    function automatic void fill_coef_tables();
        bit [63:0] s;
        bit [63:0] s60;
        bit [63:0] v;
        s60 = taylor_q30(SECTOR_DEG, 1'b1);
        for (int t = 0; t < SECTOR_DEG; t++) begin
            s = taylor_q30(t, 1'b1);
            kx_tab[t] = (s60 == 0) ? 0 : 32'(((s << 16) + (s60 >> 1)) / s60);
            v = (taylor_q30(t, 1'b0) + (64'd1 << 13)) >> 14;
            kc_tab[t] = (v > 64'd65535) ? 65535 : 32'(v);
        end
    endfunction

    function automatic void set_wheel(int m, bit dir, int unsigned wheel);
        if (wheel <= DUTY_LIMIT) begin
            duty_hold[m] = 8'((wheel * DUTY_FULL) / DUTY_LIMIT);
        end
        dir_hold[m] = dir;
    endfunction

    function automatic t_out mix_heading(t_in beat);
        int unsigned ang;
        int unsigned spd;
        int unsigned sector;
        int unsigned t;
        int unsigned x;
        int unsigned y;
        longint      yq;
        int unsigned val [3];
        bit [2:0]    dirs;
        t_out        res;
        ang = beat.heading_deg;
        spd = beat.drive_speed;
        if (ang >= FULL_TURN) begin
            ang = ang - FULL_TURN;
        end
        sector = ang / SECTOR_DEG;
        t = ang - sector * SECTOR_DEG;
        if (t == 0) begin
            val[0] = (spd * 3) >> 2;
            val[1] = val[0];
            val[2] = val[0];
        end else begin
            x = (spd * kx_tab[t]) >> 16;
            yq = longint'(spd) * longint'(kc_tab[t]) - longint'(x) * 32768;
            y = (yq < 0) ? 0 : 32'(yq >>> 16);
            val[0] = x;
            val[1] = (y > 255) ? 255 : y;
            val[2] = 0;
        end
        case (sector)
            0: dirs = 3'b100;
            1: dirs = 3'b101;
            2: dirs = 3'b001;
            3: dirs = 3'b011;
            4: dirs = 3'b010;
            5: dirs = 3'b110;
            default: dirs = 3'b110;
        endcase
        if (sector < 6) begin
            case (sector % 3)
                0: begin
                    set_wheel(0, dirs[2], val[1]);
                    set_wheel(1, dirs[1], val[0]);
                    set_wheel(2, dirs[0], val[2]);
                end
                1: begin
                    set_wheel(0, dirs[2], val[2]);
                    set_wheel(1, dirs[1], val[1]);
                    set_wheel(2, dirs[0], val[0]);
                end
                default: begin
                    set_wheel(0, dirs[2], val[0]);
                    set_wheel(1, dirs[1], val[2]);
                    set_wheel(2, dirs[0], val[1]);
                end
            endcase
        end else begin
            set_wheel(0, 1'b1, 0);
            set_wheel(1, 1'b1, 0);
            set_wheel(2, 1'b0, 0);
        end
        res.duty_one   = duty_hold[0];
        res.duty_two   = duty_hold[1];
        res.duty_three = duty_hold[2];
        res.dir_one    = dir_hold[0];
        res.dir_two    = dir_hold[1];
        res.dir_three  = dir_hold[2];
        return res;
    endfunction

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic void queue_beat(int unsigned heading, int unsigned speed);
        t_in beat;
        beat.heading_deg = 10'(heading);
        beat.drive_speed = 8'(speed);
        heading_beats.push_back(beat);
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            out_ready <= 1'b0;
        end else begin
            if (!in_valid || in_taken) begin
                if (in_gap > 0) begin
                    in_gap = in_gap - 1;
                    in_valid <= 1'b0;
                end else if (heading_beats.size() > 0) begin
                    in_data <= heading_beats.pop_front();
                    in_valid <= 1'b1;
                    if (in_burst > 0) begin
                        in_burst = in_burst - 1;
                    end else begin
                        in_gap = idle_len();
                        if ($urandom_range(0, 39) == 0) begin
                            in_burst = $urandom_range(10, 40);
                        end
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
            if (out_stall > 0) begin
                out_stall = out_stall - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (out_burst > 0) begin
                    out_burst = out_burst - 1;
                end else if ($urandom_range(0, 99) < 30) begin
                    out_stall = idle_len();
                end else if ($urandom_range(0, 49) == 0) begin
                    out_burst = $urandom_range(20, 80);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (out_valid && out_ready) begin
                if (duty_expect.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10) begin
                        $display("unexpected result beat: got %0d/%0d/%0d dir %b%b%b",
                                 out_data.duty_one, out_data.duty_two, out_data.duty_three,
                                 out_data.dir_one, out_data.dir_two, out_data.dir_three);
                    end
                end else begin
                    want = duty_expect.pop_front();
                    if (out_data.duty_one !== want.duty_one ||
                        out_data.duty_two !== want.duty_two ||
                        out_data.duty_three !== want.duty_three ||
                        out_data.dir_one !== want.dir_one ||
                        out_data.dir_two !== want.dir_two ||
                        out_data.dir_three !== want.dir_three) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10) begin
                            $display("mismatch: exp %0d/%0d/%0d dir %b%b%b got %0d/%0d/%0d dir %b%b%b",
                                     want.duty_one, want.duty_two, want.duty_three,
                                     want.dir_one, want.dir_two, want.dir_three,
                                     out_data.duty_one, out_data.duty_two,
                                     out_data.duty_three, out_data.dir_one,
                                     out_data.dir_two, out_data.dir_three);
                        end
                    end
                end
            end
            if (in_valid && in_ready) begin
                duty_expect.push_back(mix_heading(in_data));
            end
            in_taken <= in_valid && in_ready;
        end
    end

    initial begin
        int unsigned r;
        int unsigned heading;
        int unsigned speed;
        for (int m = 0; m < 3; m++) begin
            duty_hold[m] = 8'd100;
            dir_hold[m] = 1'b0;
        end
        fill_coef_tables();

        queue_beat(0, 0);
        queue_beat(0, 255);
        queue_beat(60, 100);
        queue_beat(120, 133);
        queue_beat(180, 134);
        queue_beat(240, 101);
        queue_beat(300, 255);
        queue_beat(30, 100);
        queue_beat(1, 255);
        queue_beat(59, 255);
        queue_beat(359, 0);
        queue_beat(360, 80);
        queue_beat(719, 255);
        queue_beat(720, 50);
        queue_beat(90, 170);
        queue_beat(1023, 255);
        queue_beat(45, 200);
        queue_beat(1023, 0);
        queue_beat(15, 128);
        queue_beat(600, 77);
        queue_beat(420, 40);
        queue_beat(700, 33);
        queue_beat(380, 100);
        queue_beat(5, 1);

        for (int i = 0; i < 700; i++) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                heading = $urandom_range(0, 11) * SECTOR_DEG;
            end else if (r < 85) begin
                heading = $urandom_range(0, 719);
            end else begin
                heading = $urandom_range(720, 1023);
            end
            r = $urandom_range(0, 99);
            if (r < 70) begin
                speed = $urandom_range(0, 135);
            end else if (r < 85) begin
                speed = $urandom_range(136, 255);
            end else begin
                speed = $urandom_range(0, 255);
            end
            queue_beat(heading, speed);
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (heading_beats.size() != 0 || in_valid) @(posedge i_clk);
        while (duty_expect.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        if (mismatches == 0 && duty_expect.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### files.f
hdl/odwm_pkg.sv
hdl/odwm_ctrl.sv
hdl/odwm_datapath.sv
hdl/omni_drive_wheel_mixer_core.sv
sim/omni_drive_wheel_mixer_core_test.sv
